### hw/rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared widths, codes and defaults of the chain file allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int BLK_W = 8;
   localparam int TAG_W = 64;
   localparam int CMD_W = 3;
   localparam int STAT_W = 3;

   localparam int ROOT_ENTRIES_DEF = 8;
   localparam int NUM_BLOCKS_DEF = 256;
   localparam int RESERVED_FAT_BLOCKS_DEF = 13;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_FIRST  = 3'd2,
      CMD_APPEND = 3'd3,
      CMD_UNLINK = 3'd4,
      CMD_NEXT   = 3'd5,
      CMD_LIST   = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_EXISTS      = 3'd1,
      STAT_DIR_FULL    = 3'd2,
      STAT_NOT_FOUND   = 3'd3,
      STAT_NOT_EMPTY   = 3'd4,
      STAT_DISK_FULL   = 3'd5,
      STAT_NOT_IN_FILE = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_LIST,
      S_AP_HEAD,
      S_AP_NEXT,
      S_AP_CLR,
      S_AP_WALK,
      S_IC_WALK,
      S_UL_FIX,
      S_UL_LINK,
      S_UL_FREE
   } state_type;

endpackage

### hw/rtl/fat_chain_file_allocator_unit.sv
// ----------------------------------------------------------------------------
// fat_chain_file_allocator_unit
// Root directory plus allocation table with a free chain at table entry 0.
// ----------------------------------------------------------------------------
// directory scan visits every root entry; append, unlink and next block then
//   walk the chain one table read per cycle
// list gives one word for each used entry and skips unused ones; an empty directory gives one not-found word
// throughput: one command at a time, busy is high until its last word is out
// reset: formats the table with busy high
// results are strobed on rsp_valid for one cycle; the receiver cannot stall
module fat_chain_file_allocator_unit
   import fca_pkg::*;
#(
   parameter int ROOT_ENTRIES        = ROOT_ENTRIES_DEF,
   parameter int NUM_BLOCKS          = NUM_BLOCKS_DEF,
   parameter int RESERVED_FAT_BLOCKS = RESERVED_FAT_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [TAG_W-1:0]  req_file_tag,
   input  logic [BLK_W-1:0]  req_block_index,
   output logic              rsp_valid,
   output logic [STAT_W-1:0] rsp_status,
   output logic [BLK_W-1:0]  rsp_result_block,
   output logic [TAG_W-1:0]  rsp_listed_tag,
   output logic              rsp_last
);

   localparam int IDX_W = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
   localparam int CNT_W = BLK_W + 1;
   localparam int FIRST_FREE = RESERVED_FAT_BLOCKS + 2;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [BLK_W-1:0] blk_ff, blk_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [BLK_W-1:0] b_ff, b_in;
   logic [BLK_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [BLK_W-1:0] a_ff, a_in;
   logic [BLK_W-1:0] nxt_ff, nxt_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0] rsp_block_ff, rsp_block_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic rsp_last_ff, rsp_last_in;

   logic [ROOT_ENTRIES-1:0] entry_used_ff;
   logic [TAG_W-1:0] entry_tag_ff [ROOT_ENTRIES];
   logic [BLK_W-1:0] entry_head_ff [ROOT_ENTRIES];

   logic dir_create, dir_remove, dir_head_we;
   logic [BLK_W-1:0] dir_head_val;

   logic mem_we;
   logic [BLK_W-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

   logic [BLK_W-1:0] sel_head;
   logic [ROOT_ENTRIES-1:0] used_above;
   logic [CNT_W-1:0] fmt_val;

   fca_table_ram #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign sel_head = entry_head_ff[found_idx_ff];
   assign used_above = (entry_used_ff >> idx_ff) >> 1;

   // formatted table word for the sweep address
   always_comb begin
      if (b_ff == '0) begin
         fmt_val = (FIRST_FREE < NUM_BLOCKS) ? CNT_W'(FIRST_FREE) : '0;
      end else if ({1'b0, b_ff} >= CNT_W'(FIRST_FREE) &&
                   {1'b0, b_ff} < CNT_W'(NUM_BLOCKS - 1)) begin
         fmt_val = {1'b0, b_ff} + CNT_W'(1);
      end else begin
         fmt_val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
         b_ff <= '0;
         n_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b_ff <= b_in;
         n_ff <= n_in;
      end
      cmd_ff <= cmd_in;
      tag_ff <= tag_in;
      blk_ff <= blk_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      found_idx_ff <= found_idx_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
      prev_ff <= prev_in;
      a_ff <= a_in;
      nxt_ff <= nxt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff <= rsp_block_in;
      rsp_tag_ff <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   // directory storage
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_used_ff <= '0;
      end else if (dir_create) begin
         entry_used_ff[free_idx_ff] <= 1'b1;
      end else if (dir_remove) begin
         entry_used_ff[found_idx_ff] <= 1'b0;
      end
      if (dir_create) begin
         entry_tag_ff[free_idx_ff] <= tag_ff;
         entry_head_ff[free_idx_ff] <= '0;
      end else if (dir_head_we) begin
         entry_head_ff[found_idx_ff] <= dir_head_val;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      tag_in = tag_ff;
      blk_in = blk_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      b_in = b_ff;
      prev_in = prev_ff;
      n_in = n_ff;
      a_in = a_ff;
      nxt_in = nxt_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_block_in = rsp_block_ff;
      rsp_tag_in = rsp_tag_ff;
      rsp_last_in = rsp_last_ff;
      dir_create = 1'b0;
      dir_remove = 1'b0;
      dir_head_we = 1'b0;
      dir_head_val = '0;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;

      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            mem_waddr = b_ff;
            mem_wdata = fmt_val[BLK_W-1:0];
            if ({1'b0, b_ff} == CNT_W'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end else begin
               b_in = b_ff + BLK_W'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = cmd_type'(req_command);
               tag_in = req_file_tag;
               blk_in = req_block_index;
               idx_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
               if (cmd_type'(req_command) == CMD_LIST) begin
                  state_in = S_LIST;
               end else if (cmd_type'(req_command) != CMD_NONE) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (entry_used_ff[idx_ff] && entry_tag_ff[idx_ff] == tag_ff && !found_ff) begin
               found_in = 1'b1;
               found_idx_in = idx_ff;
            end
            if (!entry_used_ff[idx_ff] && !free_ff) begin
               free_in = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == IDX_W'(ROOT_ENTRIES - 1)) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DECIDE: begin
            rsp_tag_in = '0;
            rsp_block_in = '0;
            rsp_last_in = 1'b1;
            if (cmd_ff == CMD_CREATE) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (found_ff) begin
                  rsp_status_in = STAT_EXISTS;
               end else if (free_ff) begin
                  dir_create = 1'b1;
                  rsp_status_in = STAT_OK;
               end else begin
                  rsp_status_in = STAT_DIR_FULL;
               end
            end else if (!found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               state_in = S_IDLE;
            end else begin
               case (cmd_ff)
                  CMD_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                     if (sel_head != '0) begin
                        rsp_status_in = STAT_NOT_EMPTY;
                     end else begin
                        dir_remove = 1'b1;
                        rsp_status_in = STAT_OK;
                     end
                  end
                  CMD_FIRST: begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_block_in = sel_head;
                     state_in = S_IDLE;
                  end
                  CMD_APPEND: begin
                     mem_raddr = '0;
                     state_in = S_AP_HEAD;
                  end
                  default: begin
                     // unlink and next block walk the file chain from its head
                     b_in = sel_head;
                     prev_in = sel_head;
                     n_in = '0;
                     mem_raddr = sel_head;
                     state_in = S_IC_WALK;
                  end
               endcase
            end
         end
         S_LIST: begin
            rsp_block_in = '0;
            if (entry_used_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_NOT_FOUND;
               rsp_tag_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end else if (entry_used_ff[idx_ff]) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_tag_in = entry_tag_ff[idx_ff];
               rsp_last_in = (used_above == '0);
               if (used_above == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_AP_HEAD: begin
            if (mem_rdata == '0) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_DISK_FULL;
               state_in = S_IDLE;
            end else begin
               a_in = mem_rdata;
               mem_raddr = mem_rdata;
               state_in = S_AP_NEXT;
            end
         end
         S_AP_NEXT: begin
            mem_we = 1'b1;
            mem_waddr = '0;
            mem_wdata = mem_rdata;
            state_in = S_AP_CLR;
         end
         S_AP_CLR: begin
            mem_we = 1'b1;
            mem_waddr = a_ff;
            mem_wdata = '0;
            if (sel_head == '0) begin
               dir_head_we = 1'b1;
               dir_head_val = a_ff;
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_block_in = a_ff;
               state_in = S_IDLE;
            end else begin
               b_in = sel_head;
               n_in = '0;
               mem_raddr = sel_head;
               state_in = S_AP_WALK;
            end
         end
         S_AP_WALK: begin
            if (n_ff != CNT_W'(NUM_BLOCKS) && mem_rdata != '0) begin
               b_in = mem_rdata;
               n_in = n_ff + CNT_W'(1);
               mem_raddr = mem_rdata;
            end else begin
               mem_we = 1'b1;
               mem_waddr = b_ff;
               mem_wdata = a_ff;
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_block_in = a_ff;
               state_in = S_IDLE;
            end
         end
         S_IC_WALK: begin
            // read data here is always the successor of b_ff
            if (n_ff == CNT_W'(NUM_BLOCKS) || b_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STAT_NOT_IN_FILE;
               state_in = S_IDLE;
            end else if (b_ff == blk_ff) begin
               if (cmd_ff == CMD_NEXT) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_block_in = mem_rdata;
                  state_in = S_IDLE;
               end else begin
                  nxt_in = mem_rdata;
                  state_in = S_UL_FIX;
               end
            end else begin
               prev_in = b_ff;
               b_in = mem_rdata;
               n_in = n_ff + CNT_W'(1);
               mem_raddr = mem_rdata;
            end
         end
         S_UL_FIX: begin
            if (sel_head == blk_ff) begin
               dir_head_we = 1'b1;
               dir_head_val = nxt_ff;
            end else begin
               mem_we = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = nxt_ff;
            end
            mem_raddr = '0;
            state_in = S_UL_LINK;
         end
         S_UL_LINK: begin
            mem_we = 1'b1;
            mem_waddr = blk_ff;
            mem_wdata = mem_rdata;
            state_in = S_UL_FREE;
         end
         S_UL_FREE: begin
            mem_we = 1'b1;
            mem_waddr = '0;
            mem_wdata = blk_ff;
            rsp_valid_in = 1'b1;
            rsp_status_in = STAT_OK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_listed_tag = rsp_tag_ff;
   assign rsp_last = rsp_last_ff;

`ifndef ASSERT_OFF
   a_no_word_while_format: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_valid_ff)
      else $error("result word during table format");

   a_cmd_takes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != CMD_NONE) |=> busy)
      else $error("accepted command did not raise busy");

   a_partial_only_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == S_LIST))
      else $error("non-final word outside list");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(NUM_BLOCKS))
      else $error("chain walk counter past bound");
`endif

endmodule

### hw/rtl/fca_table_ram.sv
// ----------------------------------------------------------------------------
// fca_table_ram
// Allocation table storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fca_table_ram
   import fca_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [BLK_W-1:0] wr_addr,
   input  logic [BLK_W-1:0] wr_data,
   input  logic [BLK_W-1:0] rd_addr,
   output logic [BLK_W-1:0] rd_data
);

   logic [BLK_W-1:0] mem [NUM_BLOCKS];
   logic [BLK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chain file allocator: a directed command table,
// then random file sequences, with every result word checked against a
// directory and allocation table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import fca_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NENT = ROOT_ENTRIES_DEF;
   localparam int NBLK = NUM_BLOCKS_DEF;
   localparam int NRSV = RESERVED_FAT_BLOCKS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [BLK_W-1:0]  blk;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } word_t;

   typedef struct {
      cmd_type           cmd;
      logic [TAG_W-1:0]  tag;
      logic [BLK_W-1:0]  blk;
      logic              has_exp;
      status_type        exp_status;
      logic [BLK_W-1:0]  exp_blk;
   } dir_row_t;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_command;
   logic [TAG_W-1:0]  req_file_tag;
   logic [BLK_W-1:0]  req_block_index;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [BLK_W-1:0]  rsp_result_block;
   logic [TAG_W-1:0]  rsp_listed_tag;
   logic              rsp_last;

   fat_chain_file_allocator_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_file_tag(req_file_tag),
      .req_block_index(req_block_index), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_result_block(rsp_result_block),
      .rsp_listed_tag(rsp_listed_tag), .rsp_last(rsp_last)
   );

   // model of directory and table
   logic              m_used [NENT];
   logic [TAG_W-1:0]  m_tag  [NENT];
   logic [BLK_W-1:0]  m_head [NENT];
   logic [BLK_W-1:0]  m_fat  [NBLK];

   word_t      expected_words[$];
   int         fail_count;
   int         idle_pct;
   logic [TAG_W-1:0] tag_pool[8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void format_model();
      for (int i = 0; i < NENT; i++) begin
         m_used[i] = 1'b0;
         m_tag[i] = '0;
         m_head[i] = '0;
      end
      for (int i = 0; i < NBLK; i++) m_fat[i] = '0;
      if (NRSV + 2 < NBLK) begin
         m_fat[0] = BLK_W'(NRSV + 2);
         for (int i = NRSV + 2; i < NBLK - 1; i++) m_fat[i] = BLK_W'(i + 1);
      end
   endfunction

   function automatic int find_file(logic [TAG_W-1:0] t);
      for (int i = 0; i < NENT; i++)
         if (m_used[i] && m_tag[i] == t) return i;
      return -1;
   endfunction

   function automatic bit block_in_file(logic [BLK_W-1:0] head, logic [BLK_W-1:0] b);
      logic [BLK_W-1:0] p;
      p = head;
      for (int n = 0; n < NBLK && p != 0; n++) begin
         if (p == b) return 1;
         p = m_fat[p];
      end
      return 0;
   endfunction

   function automatic void push_word(status_type s, logic [BLK_W-1:0] b,
                                     logic [TAG_W-1:0] t, logic l);
      word_t w;
      w.status = s;
      w.blk = b;
      w.tag = t;
      w.last = l;
      expected_words = {expected_words, w};
   endfunction

   // apply one command to the model, queueing its result words
   function automatic void predict_command(cmd_type c, logic [TAG_W-1:0] t,
                                           logic [BLK_W-1:0] b);
      int e, k;
      logic [BLK_W-1:0] a, p;
      if (c == CMD_LIST) begin
         k = 0;
         for (int i = 0; i < NENT; i++)
            if (m_used[i]) k++;
         if (k == 0) begin
            push_word(STAT_NOT_FOUND, '0, '0, 1'b1);
         end else begin
            for (int i = 0; i < NENT; i++)
               if (m_used[i]) begin
                  k--;
                  push_word(STAT_OK, '0, m_tag[i], k == 0);
               end
         end
         return;
      end
      if (c == CMD_NONE) return;
      e = find_file(t);
      if (c == CMD_CREATE) begin
         if (e >= 0) begin
            push_word(STAT_EXISTS, '0, '0, 1'b1);
            return;
         end
         for (int i = 0; i < NENT; i++)
            if (!m_used[i]) begin
               m_used[i] = 1'b1;
               m_tag[i] = t;
               m_head[i] = '0;
               push_word(STAT_OK, '0, '0, 1'b1);
               return;
            end
         push_word(STAT_DIR_FULL, '0, '0, 1'b1);
         return;
      end
      if (e < 0) begin
         push_word(STAT_NOT_FOUND, '0, '0, 1'b1);
         return;
      end
      case (c)
         CMD_REMOVE: begin
            if (m_head[e] != 0) push_word(STAT_NOT_EMPTY, '0, '0, 1'b1);
            else begin
               m_used[e] = 1'b0;
               push_word(STAT_OK, '0, '0, 1'b1);
            end
         end
         CMD_FIRST: push_word(STAT_OK, m_head[e], '0, 1'b1);
         CMD_APPEND: begin
            a = m_fat[0];
            if (a == 0) push_word(STAT_DISK_FULL, '0, '0, 1'b1);
            else begin
               m_fat[0] = m_fat[a];
               m_fat[a] = '0;
               if (m_head[e] == 0) m_head[e] = a;
               else begin
                  p = m_head[e];
                  for (int n = 0; n < NBLK && m_fat[p] != 0; n++) p = m_fat[p];
                  m_fat[p] = a;
               end
               push_word(STAT_OK, a, '0, 1'b1);
            end
         end
         CMD_UNLINK: begin
            if (!block_in_file(m_head[e], b)) push_word(STAT_NOT_IN_FILE, '0, '0, 1'b1);
            else begin
               if (m_head[e] == b) m_head[e] = m_fat[b];
               else begin
                  p = m_head[e];
                  for (int n = 0; n < NBLK && m_fat[p] != b && m_fat[p] != 0; n++)
                     p = m_fat[p];
                  if (m_fat[p] == b) m_fat[p] = m_fat[b];
               end
               m_fat[b] = m_fat[0];
               m_fat[0] = b;
               push_word(STAT_OK, '0, '0, 1'b1);
            end
         end
         default: begin
            if (!block_in_file(m_head[e], b)) push_word(STAT_NOT_IN_FILE, '0, '0, 1'b1);
            else push_word(STAT_OK, m_fat[b], '0, 1'b1);
         end
      endcase
   endfunction

   // check result words at the rising edge
   always @(posedge clock) begin
      word_t w;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word status=%0d blk=%0d tag=%h last=%b", $realtime,
                     rsp_status, rsp_result_block, rsp_listed_tag, rsp_last);
            fail_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_status !== w.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, w.status, rsp_status);
               fail_count++;
            end
            if (rsp_result_block !== w.blk) begin
               $display("%0t: result_block expected %0d actual %0d", $realtime, w.blk,
                        rsp_result_block);
               fail_count++;
            end
            if (rsp_listed_tag !== w.tag) begin
               $display("%0t: listed_tag expected %h actual %h", $realtime, w.tag,
                        rsp_listed_tag);
               fail_count++;
            end
            if (rsp_last !== w.last) begin
               $display("%0t: last expected %b actual %b", $realtime, w.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any result word or accepted command
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic issue(cmd_type c, logic [TAG_W-1:0] t, logic [BLK_W-1:0] b);
      // start is raised again only on a later falling edge than the one that dropped it
      do @(negedge clock); while (idle_pct > 0 && $urandom_range(99) < idle_pct);
      start <= 1'b1;
      req_command <= c;
      req_file_tag <= t;
      req_block_index <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_command(c, t, b);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (NBLK + 2 * NENT + 20) @(negedge clock);
   endtask

   function automatic logic [BLK_W-1:0] pick_block();
      case ($urandom_range(9))
         0: return BLK_W'($urandom_range(NRSV + 1));
         1: return BLK_W'(NBLK - 1);
         default: return BLK_W'($urandom_range(NBLK - 1, NRSV + 2));
      endcase
   endfunction

   dir_row_t dir_rows[$];
   function automatic void add_row(cmd_type c, logic [TAG_W-1:0] t, logic [BLK_W-1:0] b,
                                   logic h, status_type s, logic [BLK_W-1:0] eb);
      dir_row_t r;
      r.cmd = c; r.tag = t; r.blk = b; r.has_exp = h; r.exp_status = s; r.exp_blk = eb;
      dir_rows = {dir_rows, r};
   endfunction

   initial begin
      cmd_type c;
      logic [TAG_W-1:0] full_tag;
      fail_count = 0;
      idle_pct = 0;
      start = 1'b0;
      req_command = CMD_CREATE;
      req_file_tag = '0;
      req_block_index = '0;
      reset = 1'b1;
      format_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; expected status read off where obvious
      add_row(CMD_LIST,   '0, '0, 1'b1, STAT_NOT_FOUND, '0);
      add_row(CMD_FIRST,  '1, '0, 1'b1, STAT_NOT_FOUND, '0);
      add_row(CMD_CREATE, '0, '0, 1'b1, STAT_OK, '0);
      add_row(CMD_CREATE, '1, '0, 1'b1, STAT_OK, '0);
      add_row(CMD_CREATE, '1, '0, 1'b1, STAT_EXISTS, '0);
      add_row(CMD_APPEND, '1, '0, 1'b1, STAT_OK, BLK_W'(NRSV + 2));
      add_row(CMD_APPEND, '1, '0, 1'b1, STAT_OK, BLK_W'(NRSV + 3));
      add_row(CMD_FIRST,  '1, '0, 1'b1, STAT_OK, BLK_W'(NRSV + 2));
      add_row(CMD_NEXT,   '1, BLK_W'(NRSV + 2), 1'b1, STAT_OK, BLK_W'(NRSV + 3));
      add_row(CMD_NEXT,   '1, BLK_W'(NRSV + 3), 1'b1, STAT_OK, '0);
      add_row(CMD_NEXT,   '1, '0, 1'b1, STAT_NOT_IN_FILE, '0);
      add_row(CMD_UNLINK, '1, '1, 1'b1, STAT_NOT_IN_FILE, '0);
      add_row(CMD_UNLINK, '1, 8'd1, 1'b1, STAT_NOT_IN_FILE, '0);
      add_row(CMD_REMOVE, '1, '0, 1'b1, STAT_NOT_EMPTY, '0);
      add_row(CMD_NONE,   '1, '1, 1'b0, STAT_OK, '0);
      add_row(CMD_LIST,   '0, '0, 1'b0, STAT_OK, '0);
      add_row(CMD_UNLINK, '1, BLK_W'(NRSV + 2), 1'b1, STAT_OK, '0);
      add_row(CMD_UNLINK, '1, BLK_W'(NRSV + 3), 1'b1, STAT_OK, '0);
      add_row(CMD_REMOVE, '1, '0, 1'b1, STAT_OK, '0);
      add_row(CMD_REMOVE, '0, '0, 1'b1, STAT_OK, '0);
      add_row(CMD_REMOVE, '0, '0, 1'b1, STAT_NOT_FOUND, '0);
      for (int i = 0; i < NENT + 1; i++)
         add_row(CMD_CREATE, 64'hA5A5_0000_0000_0000 | i, '0, 1'b1,
                 i < NENT ? STAT_OK : STAT_DIR_FULL, '0);
      add_row(CMD_LIST,   '0, '0, 1'b0, STAT_OK, '0);

      foreach (dir_rows[i]) begin
         issue(dir_rows[i].cmd, dir_rows[i].tag, dir_rows[i].blk);
         if (dir_rows[i].has_exp && expected_words.size() > 0) begin
            if (expected_words[$].status !== dir_rows[i].exp_status ||
                expected_words[$].blk !== dir_rows[i].exp_blk) begin
               $display("%0t: table row %0d expected status %0d blk %0d, model %0d %0d",
                        $realtime, i, dir_rows[i].exp_status, dir_rows[i].exp_blk,
                        expected_words[$].status, expected_words[$].blk);
               fail_count++;
            end
         end
      end
      drain();
      for (int i = 0; i < NENT; i++)
         issue(CMD_REMOVE, 64'hA5A5_0000_0000_0000 | i, '0);

      // random phases: file lifecycles on a small tag pool, some noise
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 87 : (ph == 3) ? 25 : 0;
         for (int i = 0; i < 8; i++)
            tag_pool[i] = {$urandom, $urandom};
         for (int n = 0; n < 20; n++) begin
            logic [TAG_W-1:0] t;
            logic [BLK_W-1:0] b;
            int e;
            t = ($urandom_range(9) == 0) ? {$urandom, $urandom} : tag_pool[$urandom_range(7)];
            e = find_file(t);
            b = pick_block();
            // often aim at a block really in the file
            if (e >= 0 && m_head[e] != 0 && $urandom_range(2) != 0) begin
               b = m_head[e];
               for (int s = $urandom_range(4); s > 0 && m_fat[b] != 0; s--) b = m_fat[b];
            end
            case ($urandom_range(19))
               0, 1, 2:        c = CMD_CREATE;
               3:              c = CMD_REMOVE;
               4:              c = CMD_FIRST;
               5, 6, 7, 8, 9:  c = CMD_APPEND;
               10, 11, 12:     c = CMD_UNLINK;
               13, 14, 15:     c = CMD_NEXT;
               16, 17:         c = CMD_LIST;
               default:        c = cmd_type'($urandom_range(7));
            endcase
            // unlinking the head block before removal lets removal succeed on a file of one block
            if (c == CMD_REMOVE && e >= 0 && m_head[e] != 0) begin
               issue(CMD_UNLINK, t, m_head[e]);
               c = CMD_REMOVE;
            end
            issue(c, t, b);
         end
         // sender holds off until every word is back
         drain();
      end
      // exhaust the disk once, on any file that exists
      idle_pct = 0;
      issue(CMD_CREATE, '1, '0);
      full_tag = '1;
      if (find_file(full_tag) < 0) begin
         for (int i = NENT - 1; i >= 0; i--)
            if (m_used[i]) full_tag = m_tag[i];
      end
      for (int i = 0; i < NBLK && m_fat[0] != '0; i++) issue(CMD_APPEND, full_tag, '0);
      issue(CMD_APPEND, full_tag, '0);
      issue(CMD_LIST, '0, '0);
      drain();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
